FILE: src/abrd_pkg.sv
// Shared constants and types for the adaptive binary rANS decoder.
// No dependencies; imported by abrd_step, the top level, the checker and the testbench.
package abrd_pkg;

    localparam int WINDOW_BITS = 6;
    localparam int SLOT_BITS   = 14;
    localparam int PROB_W      = 2 * WINDOW_BITS;
    localparam int SCALE_SHIFT = SLOT_BITS - PROB_W;
    localparam int STATE_W     = 32;
    localparam int HIGH_W      = STATE_W - SLOT_BITS;
    localparam int BYTE_W      = 8;

    localparam logic [PROB_W-1:0]    PROB_HALF  = PROB_W'(1) << (PROB_W - 1);
    localparam logic [PROB_W:0]      PROB_ONE   = (PROB_W + 1)'(1) << PROB_W;
    localparam logic [SLOT_BITS:0]   SLOT_SCALE = (SLOT_BITS + 1)'(1) << SLOT_BITS;
    localparam logic [STATE_W-1:0]   RENORM_LOW = STATE_W'(1) << 23;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic [STATE_W-1:0] coder_state;
        logic [PROB_W-1:0]  one_probability;
        logic               decoded_bit;
        logic               byte_taken;
    } step_res_t;

endpackage

FILE: src/abrd_step.sv
// One decode step: slot split, state update by one multiply, renormalisation
// and probability adaptation. Purely combinational; depends on abrd_pkg.
module abrd_step
    import abrd_pkg::*;
(
    input  logic [STATE_W-1:0] coder_state,
    input  logic [PROB_W-1:0]  one_probability,
    input  logic [BYTE_W-1:0]  next_byte,
    output step_res_t          res
);

    logic [SLOT_BITS-1:0]        prob_ext;
    logic [SLOT_BITS-1:0]        p_scaled;
    logic [SLOT_BITS-1:0]        slot;
    logic [HIGH_W-1:0]           high;
    logic [SLOT_BITS:0]          zero_freq;
    logic [SLOT_BITS:0]          freq;
    logic                        is_one;
    logic [SLOT_BITS+HIGH_W:0]   prod;
    logic [STATE_W-1:0]          state_dec;
    logic [PROB_W:0]             room;
    logic [PROB_W-1:0]           prob_up;
    logic [PROB_W-1:0]           prob_down;

    always_comb
    begin
        prob_ext  = SLOT_BITS'(one_probability);
        p_scaled  = prob_ext << SCALE_SHIFT;
        slot      = coder_state[SLOT_BITS-1:0];
        high      = coder_state[STATE_W-1:SLOT_BITS];
        zero_freq = SLOT_SCALE - {1'b0, p_scaled};
        is_one    = ({1'b0, slot} >= zero_freq);
        freq      = is_one ? {1'b0, p_scaled} : zero_freq;
        prod      = freq * high;
        // wraps modulo 2^32 as the coder arithmetic does
        state_dec = prod[STATE_W-1:0] + STATE_W'(slot)
                    - (is_one ? STATE_W'(zero_freq) : '0);

        room      = PROB_ONE - {1'b0, one_probability};
        prob_up   = one_probability + PROB_W'(room >> WINDOW_BITS);
        prob_down = one_probability - (one_probability >> WINDOW_BITS);

        res.decoded_bit     = is_one;
        res.one_probability = is_one ? prob_up : prob_down;
        res.byte_taken      = (state_dec < RENORM_LOW);
        res.coder_state     = res.byte_taken
                              ? {state_dec[STATE_W-BYTE_W-1:0], next_byte}
                              : state_dec;
    end

endmodule

FILE: src/adaptive_binary_rans_decoder_unit.sv
// Adaptive binary rANS decoder: input register, combinational decode step, result register.
// Throughput one request per cycle while the result side does not stall.
// Start requests give no result and retire in the cycle after accept.
// Reset (rst_n low, asynchronous): coder state 0, one-probability one half, stages empty.
// Stalls on the result side back up through the input register.
// Depends on abrd_pkg and abrd_step.
module adaptive_binary_rans_decoder_unit
    import abrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] initial_state, [39:32] next_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] decoded_bit, [1] byte_taken, [7:2] zero
);

    logic                in_valid_reg;
    logic                in_action_reg;
    logic [STATE_W-1:0]  in_init_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    logic [STATE_W-1:0]  coder_state_reg, coder_state_next;
    logic [PROB_W-1:0]   prob_reg, prob_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_bit_reg;
    logic                out_taken_reg;

    logic                out_free;
    logic                advance;
    logic                in_take;
    logic                load_out;
    step_res_t           step;

    abrd_step u_step (
        .coder_state     (coder_state_reg),
        .one_probability (prob_reg),
        .next_byte       (in_byte_reg),
        .res             (step)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || m_axis_tready;
        advance   = in_valid_reg && ((in_action_reg == ACT_START) || out_free);
        load_out  = advance && (in_action_reg == ACT_DECODE);
        s_axis_tready = !in_valid_reg || advance;
        in_take   = s_axis_tvalid && s_axis_tready;

        coder_state_next = coder_state_reg;
        prob_next        = prob_reg;
        if (advance)
        begin
            if (in_action_reg == ACT_START)
            begin
                coder_state_next = in_init_reg;
                prob_next        = PROB_HALF;
            end
            else
            begin
                coder_state_next = step.coder_state;
                prob_next        = step.one_probability;
            end
        end

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            coder_state_reg <= '0;
            prob_reg        <= PROB_HALF;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg   <= out_valid_next;
            coder_state_reg <= coder_state_next;
            prob_reg        <= prob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= s_axis_tuser;
            in_init_reg   <= s_axis_tdata[STATE_W-1:0];
            in_byte_reg   <= s_axis_tdata[STATE_W+BYTE_W-1:STATE_W];
        end
        if (load_out)
        begin
            out_bit_reg   <= step.decoded_bit;
            out_taken_reg <= step.byte_taken;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_taken_reg, out_bit_reg};

    // estimate must never collapse to zero, else a slot width vanishes
    a_prob_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        prob_reg != '0)
        else $error("one-probability reached zero");

    // a held input request can only be waiting on a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |->
            (in_action_reg == ACT_DECODE) && out_valid_reg && !m_axis_tready)
        else $error("input stage stalled without cause");

    // start requests never create a result
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (in_action_reg == ACT_START) && !out_valid_reg) |=> !out_valid_reg)
        else $error("start request produced a result");

    // start resets the estimate to one half
    a_start_half: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_action_reg == ACT_START)) |=> prob_reg == PROB_HALF)
        else $error("start did not reset the estimate");

endmodule

FILE: test/rans_bit_checker.sv
`timescale 1ns / 1ps
// Checker for the adaptive binary rANS decoder: watches both stream channels,
// predicts each decoded bit and renormalisation flag, and counts mismatches.
// Depends on abrd_pkg for the window, slot and action constants.
module rans_bit_checker
    import abrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] initial_state, [39:32] next_byte
    input  logic        s_axis_tuser,   // [0] action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [0] decoded_bit, [1] byte_taken, [7:2] zero
    output int          bad_results,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0]       state;
        logic [PROB_W-1:0] prob;
        logic              sym;
        logic              taken;
    } symbol_step_t;

    typedef struct packed {
        logic sym;
        logic taken;
    } decoded_t;

    logic [31:0]       coder_state;
    logic [PROB_W-1:0] one_prob;
    decoded_t          pending_bits[$];

    function automatic symbol_step_t rans_decode_symbol(input logic [31:0] st,
                                                        input logic [PROB_W-1:0] p,
                                                        input logic [7:0] byte_in);
        logic [31:0]  p_scaled;
        logic [31:0]  slot;
        logic [31:0]  high;
        logic [31:0]  zero_width;
        symbol_step_t r;
        p_scaled   = 32'(p) << SCALE_SHIFT;
        slot       = st & ((32'd1 << SLOT_BITS) - 32'd1);
        high       = st >> SLOT_BITS;
        zero_width = (32'd1 << SLOT_BITS) - p_scaled;
        if (slot < zero_width)
        begin
            r.sym   = 1'b0;
            r.state = zero_width * high + slot;
            r.prob  = p - (p >> WINDOW_BITS);
        end
        else
        begin
            r.sym   = 1'b1;
            r.state = p_scaled * high + slot - zero_width;
            r.prob  = p + PROB_W'((PROB_ONE - {1'b0, p}) >> WINDOW_BITS);
        end
        r.taken = 1'b0;
        // state too low: shift the offered byte in
        if (r.state < RENORM_LOW)
        begin
            r.state = {r.state[23:0], byte_in};
            r.taken = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        symbol_step_t step;
        decoded_t     want;
        if (!rst_n)
        begin
            coder_state = '0;
            one_prob    = PROB_HALF;
            pending_bits.delete();
            bad_results = 0;
            outstanding = 0;
        end
        else
        begin
            // results first, so a request accepted this edge cannot match them
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_bits.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: unexpected result bit=%b taken=%b",
                                 $time, m_axis_tdata[0], m_axis_tdata[1]);
                end
                else
                begin
                    want = pending_bits.pop_front();
                    if (m_axis_tdata[0] !== want.sym || m_axis_tdata[1] !== want.taken ||
                        m_axis_tdata[7:2] !== 6'd0)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("%0t: expected bit=%b taken=%b, got bit=%b taken=%b pad=%h",
                                     $time, want.sym, want.taken, m_axis_tdata[0],
                                     m_axis_tdata[1], m_axis_tdata[7:2]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == ACT_START)
                begin
                    coder_state = s_axis_tdata[31:0];
                    one_prob    = PROB_HALF;
                end
                else
                begin
                    step        = rans_decode_symbol(coder_state, one_prob,
                                                     s_axis_tdata[39:32]);
                    coder_state = step.state;
                    one_prob    = step.prob;
                    want.sym    = step.sym;
                    want.taken  = step.taken;
                    pending_bits.push_back(want);
                end
            end
            outstanding = pending_bits.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top level for the adaptive binary rANS decoder test: drives start and decode
// requests with bursty timing and receiver stalls, and gives the verdict.
// Depends on abrd_pkg, adaptive_binary_rans_decoder_unit and rans_bit_checker.
module testbench
    import abrd_pkg::*;
();

    localparam int IDLE_LIMIT    = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 500;

    typedef enum int { RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RHYTHM } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    int bad_results;
    int outstanding;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit hold_req;

    adaptive_binary_rans_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rans_bit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .bad_results   (bad_results),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic offer(input logic action, input logic [31:0] init_state,
                         input logic [7:0] next_byte);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_axis_tdata  = {next_byte, init_state};
        s_axis_tuser  = action;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [31:0] pick_state();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h00FF_FFFF);
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0080_0000 | ($urandom & 32'h0000_3FFF);
            default: return $urandom_range(32'h0080_0000, 32'h7FFF_FFFF);
        endcase
    endfunction

    // receiver: changing stall pattern, plus one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS: m_axis_tready = 1'b1;
                    RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                    RX_RHYTHM: m_axis_tready = (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int  run_len;
        bit  held;
        bit  drained;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_START;
        hold_req      = 1'b0;
        items_sent    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        held          = 1'b0;
        drained       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // decode straight from the reset state
        offer(ACT_DECODE, $urandom, 8'hA5);
        offer(ACT_START, 32'h0000_0000, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'hFF);
        offer(ACT_START, 32'hFFFF_FFFF, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'h00);
        offer(ACT_DECODE, $urandom, 8'hFF);
        offer(ACT_DECODE, $urandom, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'($urandom));
        // either side of the renormalisation threshold
        offer(ACT_START, 32'h0080_0000, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'h5A);
        offer(ACT_START, 32'h007F_FFFF, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'hC3);
        offer(ACT_START, 32'h0000_3FFF, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'h81);
        // back-to-back starts, the second wins
        offer(ACT_START, 32'h8000_0000, 8'($urandom));
        offer(ACT_START, 32'h4000_0000, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'($urandom));
        offer(ACT_DECODE, $urandom, 8'($urandom));

        while (items_sent < RANDOM_ITEMS)
        begin
            if (!held && items_sent >= 150)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!drained && items_sent >= 320)
            begin
                s_axis_tvalid = 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
                drained    = 1'b1;
                burst_left = 0;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                // noise: requests in no particular order
                repeat ($urandom_range(1, 6))
                    offer(1'($urandom_range(0, 1)), $urandom, 8'($urandom));
            end
            else
            begin
                offer(ACT_START, pick_state(), 8'($urandom));
                run_len = $urandom_range(1, 40);
                repeat (run_len)
                    offer(ACT_DECODE, $urandom, 8'($urandom));
            end
        end
        s_axis_tvalid = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (bad_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
